// ----- rtl/gdg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdg_pkg
// Shared types, constants and the tangent boundary table of the gradient
// direction gate.
// ----------------------------------------------------------------------------
package gdg_pkg;

  localparam int ANGLE_FRAC_BITS = 8;

  // Boundaries of the rounded angle inside one octant: n + e for n in 0..44 and
  // n - e for n in 1..45, each n a whole degree, where e is half an angle LSB.
  localparam int NUM_BOUND = 2 * 45;
  localparam int POS_W     = $clog2(NUM_BOUND + 1);

  localparam int GRAD_W = 11;
  localparam int MAG_W  = 8;
  localparam int TAN_W  = 40;
  localparam int PROD_W = GRAD_W + TAN_W;

  localparam real PI         = 3.14159265358979323846;
  localparam real TAN_SCALE  = 2.0 ** TAN_W;
  localparam real DEG_TO_RAD = PI / 180.0;
  localparam real HALF_LSB   = 1.0 / (2.0 ** (ANGLE_FRAC_BITS + 1));

  typedef logic [TAN_W-1:0] tan_tbl_t [NUM_BOUND];

  // One pixel on its way through the search pipeline.
  typedef struct packed {
    logic [GRAD_W-1:0] a;      // smaller absolute gradient
    logic [GRAD_W-1:0] b;      // larger absolute gradient
    logic              swap;   // |gy| > |gx|
    logic              x_neg;
    logic              y_neg;
    logic              zero;
    logic [MAG_W-1:0]  mag;
    logic [POS_W-1:0]  pos;    // boundaries passed so far
  } gdg_item_t;

  // Elaboration only: 1/v for v >= 0.5, Newton steps from a power-of-two guess.
  function automatic real recip(input real v);
    real p;
    real r;
    int  k;
    p = 1.0;
    r = 1.0;
    for (k = 0; k < 12; k++) begin
      if (p <= v) begin
        p = p * 2.0;
        r = r * 0.5;
      end
    end
    for (k = 0; k < 8; k++) begin
      r = r * (2.0 - v * r);
    end
    return r;
  endfunction

  // Elaboration only: tan of every octant boundary, unsigned Q0.TAN_W.
  function automatic tan_tbl_t build_tan_table();
    tan_tbl_t tbl;
    real      deg;
    real      x;
    real      x2;
    real      s;
    real      c;
    real      ts;
    real      tc;
    int       i;
    int       k;
    for (i = 0; i < NUM_BOUND; i++) begin
      if ((i & 1) == 1) begin
        deg = real'((i + 1) >> 1) - HALF_LSB;
      end else begin
        deg = real'(i >> 1) + HALF_LSB;
      end
      x  = deg * DEG_TO_RAD;
      x2 = x * x;
      s  = x;
      c  = 1.0;
      ts = x;
      tc = 1.0;
      for (k = 1; k <= 14; k++) begin
        ts = -ts * x2 * recip(real'((2 * k) * (2 * k + 1)));
        tc = -tc * x2 * recip(real'((2 * k - 1) * (2 * k)));
        s  = s + ts;
        c  = c + tc;
      end
      tbl[i] = TAN_W'(longint'(s * recip(c) * TAN_SCALE));
    end
    return tbl;
  endfunction

  localparam tan_tbl_t TAN_TABLE = build_tan_table();

  function automatic logic [TAN_W-1:0] tan_bound(input logic [POS_W-1:0] idx);
    logic [TAN_W-1:0] t;
    t = '0;
    if (idx < POS_W'(NUM_BOUND)) begin
      t = TAN_TABLE[idx];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gdg_search_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdg_search_step
// One step of the binary search over the octant boundaries: compare a/b
// against the tangent of the probed boundary and register the result.
// ----------------------------------------------------------------------------
module gdg_search_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  gdg_pkg::gdg_item_t       item_i,
  input  logic [gdg_pkg::POS_W-1:0] probe_bit_i,
  input  logic                     down_en_i,
  output logic                     up_en_o,
  output logic                     valid_o,
  output gdg_pkg::gdg_item_t       item_o
);

  logic [gdg_pkg::POS_W-1:0]  probe;
  logic                       in_range;
  logic [gdg_pkg::POS_W-1:0]  idx;
  logic [gdg_pkg::TAN_W-1:0]  tan_val;
  logic [gdg_pkg::PROD_W-1:0] lhs;
  logic [gdg_pkg::PROD_W-1:0] rhs;
  logic                       hit;
  gdg_pkg::gdg_item_t         item_d;
  gdg_pkg::gdg_item_t         item_q;
  logic                       valid_q;

  // Lower bits of pos are still zero here, so the OR is pos + 2^step.
  assign probe    = item_i.pos | probe_bit_i;
  assign in_range = (probe <= gdg_pkg::POS_W'(gdg_pkg::NUM_BOUND));
  assign idx      = in_range ? (probe - gdg_pkg::POS_W'(1)) : '0;
  assign tan_val  = gdg_pkg::tan_bound(idx);

  // atan(a/b) >= boundary  <=>  a * 2^TAN_W >= b * tan(boundary)
  assign lhs = {item_i.a, {gdg_pkg::TAN_W{1'b0}}};
  assign rhs = gdg_pkg::PROD_W'(item_i.b) * gdg_pkg::PROD_W'(tan_val);
  assign hit = in_range && (lhs >= rhs);

  always_comb begin
    item_d = item_i;
    if (hit) begin
      item_d.pos = probe;
    end
  end

  assign up_en_o = !valid_q || down_en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_en_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ----- rtl/gradient_direction_gate_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_direction_gate_core
// Gradient magnitude gated by direction window and by threshold.
// ----------------------------------------------------------------------------
// Takes one pixel each clock while in_stall_o is low and passes it through
// one input stage that folds the gradient into the first octant and forms the
// magnitude, seven binary-search stages that each compare the octant
// ratio against one tangent boundary with an 11 x 40 bit multiply, and an
// output stage that unfolds the direction and applies both gates. Bubbles
// collapse as the output stalls; a full pipeline holds nine requests.
// ----------------------------------------------------------------------------
module gradient_direction_gate_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [gdg_pkg::GRAD_W-1:0] grad_x_i,
  input  logic signed [gdg_pkg::GRAD_W-1:0] grad_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gdg_pkg::MAG_W-1:0]   direction_gated_o,
  output logic [gdg_pkg::MAG_W-1:0]   threshold_gated_o
);

  typedef enum logic {
    CFG_CENTER = 1'b0,
    CFG_THRESH = 1'b1
  } gdg_cfg_e;

  localparam int NSTEP    = gdg_pkg::POS_W;
  // Direction in half-degree steps: even codes sit on a whole degree.
  localparam int QUARTER_H = 180;
  localparam int HALF_H    = 360;
  localparam int WIN_H     = 2 * 20;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [7:0] center_q;
  logic [7:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gdg_cfg_e'(cfg_idx_i))
        CFG_CENTER: center_q <= cfg_data_i;
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: absolute values, octant fold, magnitude
  // --------------------------------------------------------------------------
  logic [gdg_pkg::GRAD_W:0]   gx_ext;
  logic [gdg_pkg::GRAD_W:0]   gy_ext;
  logic [gdg_pkg::GRAD_W:0]   ax_full;
  logic [gdg_pkg::GRAD_W:0]   ay_full;
  logic [gdg_pkg::GRAD_W-1:0] ax;
  logic [gdg_pkg::GRAD_W-1:0] ay;
  logic [gdg_pkg::MAG_W-1:0]  sx;
  logic [gdg_pkg::MAG_W-1:0]  sy;
  logic [gdg_pkg::MAG_W:0]    mag_sum;
  gdg_pkg::gdg_item_t         s0_d;
  gdg_pkg::gdg_item_t         s0_q;
  logic                       s0_valid_q;
  logic                       s0_en;

  assign gx_ext  = {grad_x_i[gdg_pkg::GRAD_W-1], grad_x_i};
  assign gy_ext  = {grad_y_i[gdg_pkg::GRAD_W-1], grad_y_i};
  assign ax_full = grad_x_i[gdg_pkg::GRAD_W-1] ? (~gx_ext + 1'b1) : gx_ext;
  assign ay_full = grad_y_i[gdg_pkg::GRAD_W-1] ? (~gy_ext + 1'b1) : gy_ext;
  assign ax      = ax_full[gdg_pkg::GRAD_W-1:0];
  assign ay      = ay_full[gdg_pkg::GRAD_W-1:0];

  assign sx      = (ax > gdg_pkg::GRAD_W'(255)) ? 8'hFF : ax[gdg_pkg::MAG_W-1:0];
  assign sy      = (ay > gdg_pkg::GRAD_W'(255)) ? 8'hFF : ay[gdg_pkg::MAG_W-1:0];
  assign mag_sum = {1'b0, sx} + {1'b0, sy};

  always_comb begin
    s0_d.swap  = (ay > ax);
    s0_d.a     = s0_d.swap ? ax : ay;
    s0_d.b     = s0_d.swap ? ay : ax;
    s0_d.x_neg = grad_x_i[gdg_pkg::GRAD_W-1];
    s0_d.y_neg = grad_y_i[gdg_pkg::GRAD_W-1];
    s0_d.zero  = (ax == '0) && (ay == '0);
    // halve, round half to even
    s0_d.mag   = mag_sum[gdg_pkg::MAG_W:1]
               + gdg_pkg::MAG_W'(mag_sum[0] & mag_sum[1]);
    s0_d.pos   = '0;
  end

  logic               step_valid [NSTEP];
  gdg_pkg::gdg_item_t step_item  [NSTEP];
  logic               step_en    [NSTEP];
  logic               out_en;

  assign s0_en      = !s0_valid_q || step_en[0];
  assign in_stall_o = !s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_en && in_valid_i) begin
      s0_q <= s0_d;
    end
  end

  // --------------------------------------------------------------------------
  // Binary search over the octant boundaries, largest step first
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    localparam logic [gdg_pkg::POS_W-1:0] ProbeBit =
      gdg_pkg::POS_W'(1) << (NSTEP - 1 - s);

    logic               up_valid;
    gdg_pkg::gdg_item_t up_item;
    logic               down_en;

    if (s == 0) begin : g_first
      assign up_valid = s0_valid_q;
      assign up_item  = s0_q;
    end else begin : g_next
      assign up_valid = step_valid[s-1];
      assign up_item  = step_item[s-1];
    end

    if (s == NSTEP - 1) begin : g_last
      assign down_en = out_en;
    end else begin : g_mid
      assign down_en = step_en[s+1];
    end

    gdg_search_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (up_valid),
      .item_i      (up_item),
      .probe_bit_i (ProbeBit),
      .down_en_i   (down_en),
      .up_en_o     (step_en[s]),
      .valid_o     (step_valid[s]),
      .item_o      (step_item[s])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: unfold the direction, apply both gates
  // --------------------------------------------------------------------------
  gdg_pkg::gdg_item_t fin;
  logic               fin_valid;
  logic [7:0]         h_phi;
  logic [8:0]         h_theta;
  logic signed [9:0]  h_signed;
  logic signed [10:0] h_diff;
  logic               in_window;
  logic               above_thresh;
  logic [gdg_pkg::MAG_W-1:0] dir_d;
  logic [gdg_pkg::MAG_W-1:0] thr_d;
  logic [gdg_pkg::MAG_W-1:0] dir_q;
  logic [gdg_pkg::MAG_W-1:0] thr_q;
  logic               out_valid_q;

  assign fin       = step_item[NSTEP-1];
  assign fin_valid = step_valid[NSTEP-1];

  always_comb begin
    h_phi = fin.swap ? (8'(QUARTER_H) - 8'(fin.pos)) : 8'(fin.pos);
    if (fin.zero) begin
      h_theta = '0;
    end else if (fin.x_neg) begin
      h_theta = 9'(HALF_H) - {1'b0, h_phi};
    end else begin
      h_theta = {1'b0, h_phi};
    end
    h_signed = fin.y_neg ? -$signed({1'b0, h_theta}) : $signed({1'b0, h_theta});
    h_diff   = $signed({h_signed[9], h_signed}) - $signed({2'b00, center_q, 1'b0});
  end

  assign in_window    = (h_diff >= -11'sd40) && (h_diff < 11'(WIN_H));
  assign above_thresh = (fin.mag > thresh_q);
  assign dir_d        = in_window ? fin.mag : '0;
  assign thr_d        = above_thresh ? fin.mag : '0;

  assign out_en = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && fin_valid) begin
      dir_q <= dir_d;
      thr_q <= thr_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign direction_gated_o = dir_q;
  assign threshold_gated_o = thr_q;

`ifndef SYNTH
  // Hold a stalled result steady.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(direction_gated_o) &&
     $stable(threshold_gated_o)))
    else $error("stalled result changed");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid |-> (fin.pos <= gdg_pkg::POS_W'(gdg_pkg::NUM_BOUND)))
    else $error("search position beyond boundary count");

  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid && out_en && fin.zero && (center_q <= 8'd20) && !cfg_we_i)
    |=> (direction_gated_o == $past(fin.mag)))
    else $error("zero gradient dropped from window around zero");

  a_thresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((threshold_gated_o == '0) || (threshold_gated_o > thresh_q)))
    else $error("threshold output passed a small magnitude");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/gdg_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_result_checker
// Watches the config port and both request channels of the gradient
// direction gate, predicts the gated magnitudes and compares them in order.
// ----------------------------------------------------------------------------
package gdg_tb_pkg;

  typedef enum logic {
    CFG_CENTER_ANGLE  = 1'b0,
    CFG_MAG_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] direction_gated;
    logic [7:0] threshold_gated;
  } gate_result_t;

  localparam real DEG_PER_RAD = 57.295779513082320876798;

endpackage

module gdg_result_checker
  import gdg_tb_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [gdg_pkg::GRAD_W-1:0] grad_x_i,
  input  logic signed [gdg_pkg::GRAD_W-1:0] grad_y_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [gdg_pkg::MAG_W-1:0]         direction_gated_i,
  input  logic [gdg_pkg::MAG_W-1:0]         threshold_gated_i,
  output int                                mismatch_count_o,
  output int                                pending_count_o
);

  localparam int ANGLE_F = gdg_pkg::ANGLE_FRAC_BITS;

  gate_result_t gated_mag_q[$];
  logic [7:0]   center_angle;
  logic [7:0]   mag_threshold;
  int           mismatches;

  function automatic gate_result_t gate_magnitude(input logic signed [10:0] gx,
                                                  input logic signed [10:0] gy,
                                                  input logic [7:0]        center,
                                                  input logic [7:0]        thresh);
    int           gx_v;
    int           gy_v;
    int           sat_x;
    int           sat_y;
    int           mag_sum;
    int           mag;
    real          deg;
    longint       angle_q;
    longint       diff;
    longint       bound;
    gate_result_t res;
    gx_v    = gx;
    gy_v    = gy;
    sat_x   = (gx_v < 0) ? -gx_v : gx_v;
    sat_y   = (gy_v < 0) ? -gy_v : gy_v;
    sat_x   = (sat_x > 255) ? 255 : sat_x;
    sat_y   = (sat_y > 255) ? 255 : sat_y;
    mag_sum = sat_x + sat_y;
    // round half to even
    mag     = (mag_sum >> 1) + ((mag_sum & 1) & ((mag_sum >> 1) & 1));
    if (gx_v == 0 && gy_v == 0) begin
      angle_q = 0;
    end else begin
      // no exact ties exist for integer gradients, so symmetric rounding holds
      deg     = $atan2(real'(gy_v), real'(gx_v)) * DEG_PER_RAD;
      angle_q = longint'(deg * real'(longint'(1) << ANGLE_F));
    end
    diff  = angle_q - (longint'(center) << ANGLE_F);
    bound = longint'(20) << ANGLE_F;
    res.direction_gated = (diff >= -bound && diff < bound) ? mag[7:0] : 8'd0;
    res.threshold_gated = (mag > int'(thresh)) ? mag[7:0] : 8'd0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gate_result_t exp_res;
    if (!rst_ni) begin
      center_angle  = '0;
      mag_threshold = '0;
      gated_mag_q.delete();
      mismatches    = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_ANGLE:  center_angle  = cfg_data_i;
          CFG_MAG_THRESHOLD: mag_threshold = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        gated_mag_q.push_back(gate_magnitude(grad_x_i, grad_y_i, center_angle,
                                             mag_threshold));
      end
      if (out_valid_i && !out_stall_i) begin
        if (gated_mag_q.size() == 0) begin
          $error("result with nothing outstanding: direction_gated %0d threshold_gated %0d",
                 direction_gated_i, threshold_gated_i);
          mismatches++;
        end else begin
          exp_res = gated_mag_q.pop_front();
          if (direction_gated_i !== exp_res.direction_gated) begin
            $error("direction_gated expected %0d actual %0d",
                   exp_res.direction_gated, direction_gated_i);
            mismatches++;
          end
          if (threshold_gated_i !== exp_res.threshold_gated) begin
            $error("threshold_gated expected %0d actual %0d",
                   exp_res.threshold_gated, threshold_gated_i);
            mismatches++;
          end
        end
      end
      // publish after the edge so readers at the edge see settled counts
      mismatch_count_o <= mismatches;
      pending_count_o  <= gated_mag_q.size();
    end
  end

endmodule

// ----- tb/sv/gradient_direction_gate_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_direction_gate_core_tb
// Drives gradient pairs and config writes into the direction gate under
// random sender gaps and receiver stalls; the result checker grades output.
// ----------------------------------------------------------------------------
module gradient_direction_gate_core_tb;
  import gdg_tb_pkg::*;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int SETTLE_CYCLES    = 24;
  localparam int NUM_PHASES       = 8;
  localparam int PIXELS_PER_PHASE = 205;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic                              cfg_idx_i;
  logic [7:0]                        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [gdg_pkg::GRAD_W-1:0] grad_x_i;
  logic signed [gdg_pkg::GRAD_W-1:0] grad_y_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [gdg_pkg::MAG_W-1:0]         direction_gated_o;
  logic [gdg_pkg::MAG_W-1:0]         threshold_gated_o;

  int         mismatch_count;
  int         pending_count;
  int         idle_cycles;
  int         burst_left;
  bit         gaps_on;
  logic [7:0] cur_center;

  int stall_mode   = 0;
  int stall_left   = 0;
  int stall_period = 4;
  int stall_on     = 1;
  int stall_phase  = 0;

  gradient_direction_gate_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .grad_x_i          (grad_x_i),
    .grad_y_i          (grad_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .direction_gated_o (direction_gated_o),
    .threshold_gated_o (threshold_gated_o)
  );

  gdg_result_checker u_result_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .grad_x_i          (grad_x_i),
    .grad_y_i          (grad_y_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .direction_gated_i (direction_gated_o),
    .threshold_gated_i (threshold_gated_o),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // receiver: switch between no stall, light random, periodic and heavy random
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_left   = $urandom_range(40, 300);
      stall_period = $urandom_range(2, 16);
      stall_on     = $urandom_range(1, stall_period - 1);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % stall_period;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 30);
      2:       out_stall_i <= (stall_phase < stall_on);
      default: out_stall_i <= ($urandom_range(0, 99) < 75);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int clamp_grad(input int v);
    return (v > 1023) ? 1023 : ((v < -1024) ? -1024 : v);
  endfunction

  // hold the request until accepted; open a gap when the burst runs out
  task automatic send_pixel(input int gx, input int gy);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    grad_x_i   <= gx[10:0];
    grad_y_i   <= gy[10:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  // drop valid and let the pipeline empty before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] center, input logic [7:0] thresh);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CENTER_ANGLE;
    cfg_data_i <= center;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAG_THRESHOLD;
    cfg_data_i <= thresh;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_center  = center;
  endtask

  task automatic pick_pixel(output int gx, output int gy);
    real theta;
    int  radius;
    int  m;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        gx = int'($urandom_range(0, 2047)) - 1024;
        gy = int'($urandom_range(0, 2047)) - 1024;
      end
      3: begin
        gx = int'($urandom_range(0, 16)) - 8;
        gy = int'($urandom_range(0, 16)) - 8;
      end
      4, 8: begin
        // aim just inside or outside a window edge
        theta  = (real'(cur_center) + ($urandom_range(0, 1) ? 20.0 : -20.0)
                  + (real'($urandom_range(0, 2000)) - 1000.0) * 0.0005) / DEG_PER_RAD;
        radius = $urandom_range(8, 1100);
        gx     = clamp_grad(int'(radius * $cos(theta)));
        gy     = clamp_grad(int'(radius * $sin(theta)));
      end
      5: begin
        m = int'($urandom_range(0, 2047)) - 1024;
        if ($urandom_range(0, 1)) begin
          gx = m;
          gy = 0;
        end else begin
          gx = 0;
          gy = m;
        end
      end
      6: begin
        m  = $urandom_range(0, 1024);
        gx = clamp_grad($urandom_range(0, 1) ? -m : m);
        gy = clamp_grad($urandom_range(0, 1) ? -m : m);
      end
      7: begin
        gx = int'($urandom_range(0, 600)) - 300;
        gy = int'($urandom_range(0, 600)) - 300;
      end
      default: begin
        gx = int'($urandom_range(0, 2047)) - 1024;
        gy = int'($urandom_range(0, 6)) - 3;
      end
    endcase
  endtask

  initial begin
    int         gx;
    int         gy;
    logic [7:0] center;
    logic [7:0] thresh;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_CENTER_ANGLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    grad_x_i   = '0;
    grad_y_i   = '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    cur_center = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: window [-20, 20), threshold 0
    send_pixel(0, 0);          // zero gradient, angle 0
    send_pixel(-5, 0);         // negative horizontal, +180
    send_pixel(5, 0);
    send_pixel(0, 5);
    send_pixel(0, -5);
    send_pixel(1023, 1023);
    send_pixel(-1024, -1024);
    send_pixel(1023, -1024);
    send_pixel(-1024, 1023);
    send_pixel(255, 0);        // odd sum rounds up to even
    send_pixel(1, 0);          // half rounds down to zero
    send_pixel(2, 1);
    send_pixel(256, 0);
    send_pixel(1000, 363);     // just inside the upper edge
    send_pixel(1000, 364);     // upper edge excluded
    send_pixel(1000, -364);    // lower edge included
    send_pixel(1000, -365);
    send_pixel(-1, 0);
    send_pixel(0, -1024);
    send_pixel(-1024, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin center = 8'd0;   thresh = 8'd0;   end
        1: begin center = 8'd180; thresh = 8'd255; end
        2: begin center = 8'd255; thresh = 8'd128; end
        3: begin center = 8'd45;  thresh = 8'd1;   end
        4: begin center = 8'd200; thresh = 8'd254; end
        5: begin center = 8'd135; thresh = 8'd64;  end
        default: begin
          center = 8'($urandom_range(0, 255));
          thresh = 8'($urandom_range(0, 255));
        end
      endcase
      write_config(center, thresh);
      gaps_on    = (p % 3 != 1);
      burst_left = 0;
      repeat (PIXELS_PER_PHASE) begin
        pick_pixel(gx, gy);
        send_pixel(gx, gy);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gdg_pkg.sv
rtl/gdg_search_step.sv
rtl/gradient_direction_gate_core.sv
tb/sv/gdg_result_checker.sv
tb/sv/gradient_direction_gate_core_tb.sv
